FILE: hw/rtl/srad_pkg.sv
package srad_pkg;

    localparam int PIX_W   = 16;
    localparam int COEF_W  = 48;
    localparam int IDX_W   = 8;
    localparam int CFG_W   = 32;

    localparam logic [IDX_W-1:0] REG_Q0     = 8'd0;
    localparam logic [IDX_W-1:0] REG_BYPASS = 8'd1;

    localparam logic [COEF_W-1:0] ONE_Q24 = 48'h000001000000;
    localparam logic [COEF_W-1:0] SAT48   = {COEF_W{1'b1}};

    // controller -> datapath commands
    typedef struct packed {
        logic       load;      // latch new column into the window
        logic       clear;     // row start: zero the window first
        logic       calc;      // evaluate the stencil at the window head
        logic       shift;     // advance window after emission
    } srad_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic done;            // coefficient triple ready in result register
    } srad_sts_t;

endpackage

FILE: hw/rtl/srad_coeff.sv
// One coefficient, four register stages: squares, partial products, exact sums,
// scale/select.
module srad_coeff
    import srad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [15:0]       q0,
    input  logic              bypass,
    input  logic [PIX_W-1:0]  n,
    input  logic [PIX_W-1:0]  c,
    input  logic [PIX_W-1:0]  s,
    input  logic [PIX_W-1:0]  w,
    input  logic [PIX_W-1:0]  e,
    output logic              done,
    output logic [COEF_W-1:0] value,
    output logic [COEF_W-1:0] tag
);
    logic [3:0] vld_reg, vld_next;

    // stage 1: sums, squares
    logic [17:0] a_s;
    logic [17:0] c4;
    logic [17:0] babs;
    logic [15:0] dn, ds, dw, dwe;
    logic [16:0] q0_one;
    logic [31:0] sqn_reg, sqs_reg, sqw_reg, sqe_reg;
    logic [35:0] bsq_reg;
    logic [35:0] a2_reg;
    logic [32:0] d0_reg;
    logic [31:0] qq_reg;
    logic        force_reg;

    function automatic logic [15:0] adiff(input logic [15:0] x, input logic [15:0] y);
        adiff = (x >= y) ? x - y : y - x;
    endfunction

    always_comb
    begin
        a_s    = {2'b0, n} + {2'b0, s} + {2'b0, w} + {2'b0, e};
        c4     = {c, 2'b00};
        babs   = (a_s >= c4) ? a_s - c4 : c4 - a_s;
        dn     = adiff(n, c);
        ds     = adiff(s, c);
        dw     = adiff(w, c);
        dwe    = adiff(e, c);
        q0_one = {1'b1, 16'h0000} + {1'b0, q0};
    end

    always_ff @(posedge clk)
    begin
        sqn_reg   <= {16'b0, dn} * {16'b0, dn};
        sqs_reg   <= {16'b0, ds} * {16'b0, ds};
        sqw_reg   <= {16'b0, dw} * {16'b0, dw};
        sqe_reg   <= {16'b0, dwe} * {16'b0, dwe};
        bsq_reg   <= {18'b0, babs} * {18'b0, babs};
        a2_reg    <= {18'b0, a_s} * {18'b0, a_s};
        d0_reg    <= {17'b0, q0} * {16'b0, q0_one};
        qq_reg    <= {16'b0, q0} * {16'b0, q0};
        force_reg <= bypass || (q0 == '0) || (c == '0);
    end

    // stage 2: deviation term, products on the two halves of a^2
    logic [33:0] ssum;
    logic [36:0] nq_reg;
    logic [50:0] pn_lo_reg, pn_hi_reg;
    logic [49:0] pd_lo_reg, pd_hi_reg;
    logic        force2_reg;

    assign ssum = {2'b0, sqn_reg} + {2'b0, sqs_reg} + {2'b0, sqw_reg} + {2'b0, sqe_reg};

    always_ff @(posedge clk)
    begin
        nq_reg     <= {ssum, 3'b000} - {1'b0, bsq_reg};
        pn_lo_reg  <= {18'b0, d0_reg} * {33'b0, a2_reg[17:0]};
        pn_hi_reg  <= {18'b0, d0_reg} * {33'b0, a2_reg[35:18]};
        pd_lo_reg  <= {18'b0, qq_reg} * {32'b0, a2_reg[17:0]};
        pd_hi_reg  <= {18'b0, qq_reg} * {32'b0, a2_reg[35:18]};
        force2_reg <= force_reg;
    end

    // stage 3: exact numerator and denominator
    logic [86:0] num_reg, den_reg;
    logic        force3_reg;
    always_ff @(posedge clk)
    begin
        num_reg    <= {36'b0, pn_lo_reg} + {18'b0, pn_hi_reg, 18'b0};
        den_reg    <= {37'b0, pd_lo_reg} + {19'b0, pd_hi_reg, 18'b0}
                    + {18'b0, nq_reg, 32'b0};
        force3_reg <= force2_reg;
    end

    // stage 4: scale, saturate, select
    logic [COEF_W-1:0] ns, dsc, val_next, tag_next;
    always_comb
    begin
        ns  = (num_reg[86:76] != '0) ? SAT48 : num_reg[75:28];
        dsc = (den_reg[86:76] != '0) ? SAT48 : den_reg[75:28];
        priority if (force3_reg)
        begin
            val_next = ONE_Q24; tag_next = '0;
        end
        else if (ns == '0 || dsc == '0)
        begin
            val_next = '0; tag_next = '0;
        end
        else if (dsc <= ns)
        begin
            val_next = ONE_Q24; tag_next = '0;
        end
        else
        begin
            val_next = ns; tag_next = dsc;
        end
    end

    always_ff @(posedge clk)
    begin
        value <= val_next;
        tag   <= tag_next;
    end

    assign vld_next = {vld_reg[2:0], start};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= '0;
        else        vld_reg <= vld_next;
    end
    assign done = vld_reg[3];
endmodule

FILE: hw/rtl/srad_datapath.sv
// Column window and three coefficient units.
module srad_datapath
    import srad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  srad_cmd_t         cmd,
    output srad_sts_t         sts,
    input  logic [15:0]       q0,
    input  logic              bypass,
    input  logic [4*PIX_W-1:0] col_in,
    output logic [6*COEF_W-1:0] res
);
    // win_reg[0..2] previous columns k-1.., win_reg[3] newest
    logic [PIX_W-1:0] win_reg [6][4];
    logic [PIX_W-1:0] win_next[6][4];

    always_comb
    begin
        win_next = win_reg;
        if (cmd.load)
        begin
            for (int i = 0; i < 6; i++)
                for (int r = 0; r < 4; r++)
                    win_next[i][r] = '0;
            if (!cmd.clear)
                for (int i = 0; i < 3; i++)
                    for (int r = 0; r < 4; r++)
                        win_next[i][r] = win_reg[i+1][r];
            for (int r = 0; r < 4; r++)
                win_next[3][r] = col_in[r*PIX_W +: PIX_W];
        end
        else if (cmd.shift)
        begin
            for (int i = 0; i < 5; i++)
                for (int r = 0; r < 4; r++)
                    win_next[i][r] = win_reg[i+1][r];
            for (int r = 0; r < 4; r++)
                win_next[5][r] = '0;
        end
    end

    // window layout: slots 0..3 hold columns k-1..k+2 of the emitted stencil;
    // flush reads shifted window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                for (int r = 0; r < 4; r++)
                    win_reg[i][r] <= '0;
        end
        else
            win_reg <= win_next;
    end

    logic [2:0] dn;
    logic [COEF_W-1:0] v0, t0, v1, t1, v2, t2;

    srad_coeff u_c (.clk, .rst_n, .start(cmd.calc), .q0, .bypass,
        .n(win_reg[1][0]), .c(win_reg[1][1]), .s(win_reg[1][2]),
        .w(win_reg[0][1]), .e(win_reg[2][1]), .done(dn[0]), .value(v0), .tag(t0));
    srad_coeff u_s (.clk, .rst_n, .start(cmd.calc), .q0, .bypass,
        .n(win_reg[1][1]), .c(win_reg[1][2]), .s(win_reg[1][3]),
        .w(win_reg[0][2]), .e(win_reg[2][2]), .done(dn[1]), .value(v1), .tag(t1));
    srad_coeff u_e (.clk, .rst_n, .start(cmd.calc), .q0, .bypass,
        .n(win_reg[2][0]), .c(win_reg[2][1]), .s(win_reg[2][2]),
        .w(win_reg[1][1]), .e(win_reg[3][1]), .done(dn[2]), .value(v2), .tag(t2));

    assign res = {t2, v2, t1, v1, t0, v0};
    assign sts.done = &dn;
endmodule

FILE: hw/rtl/srad_ctrl.sv
// Sequencer: one column in, zero/one/three stencils out, output hold.
module srad_ctrl
    import srad_pkg::*;
#(
    parameter int ROW_WIDTH = 256
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output logic      out_last,
    output logic      out_load,
    output srad_cmd_t cmd,
    input  srad_sts_t sts
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CALC = 5'b00010,
        S_WAIT = 5'b00100,
        S_OUT  = 5'b01000,
        S_SHFT = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [11:0] cnt_reg, cnt_next;
    logic [1:0]  left_reg, left_next;   // stencils still to emit for this item
    logic        last_reg, last_next;
    logic        oval_reg, oval_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        last_next  = last_reg;
        oval_next  = oval_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        out_load   = 1'b0;
        if (oval_reg && out_ready)
            oval_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load  = 1'b1;
                    cmd.clear = (cnt_reg == '0);
                    if (cnt_reg >= 12'(ROW_WIDTH - 1))
                    begin
                        left_next  = 2'd3;
                        cnt_next   = '0;
                        state_next = S_CALC;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 12'd1;
                        if (cnt_reg >= 12'd2)
                        begin
                            left_next  = 2'd1;
                            state_next = S_CALC;
                        end
                    end
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.done && !oval_next)
                begin
                    out_load   = 1'b1;
                    oval_next  = 1'b1;
                    last_next  = (left_reg == 2'd1) && (cnt_reg == '0);
                    left_next  = left_reg - 2'd1;
                    state_next = (left_reg == 2'd1) ? S_IDLE : S_SHFT;
                end
                else if (sts.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!oval_next)
                begin
                    out_load   = 1'b1;
                    oval_next  = 1'b1;
                    last_next  = (left_reg == 2'd1) && (cnt_reg == '0);
                    left_next  = left_reg - 2'd1;
                    state_next = (left_reg == 2'd1) ? S_IDLE : S_SHFT;
                end
            end
            S_SHFT:
            begin
                cmd.shift  = 1'b1;
                state_next = S_CALC;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            left_reg  <= '0;
            last_reg  <= 1'b0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
            last_reg  <= last_next;
            oval_reg  <= oval_next;
        end
    end

    assign out_valid = oval_reg;
    assign out_last  = last_reg;

`ifndef SYNTHESIS
    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("accept while busy");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> !oval_reg || out_ready) else $error("result overwritten");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < 12'(ROW_WIDTH)) else $error("column count out of range");
`endif
endmodule

FILE: hw/rtl/srad_diffusion_coeff_stencil_core.sv
// SRAD diffusion coefficient stencil core.
// Path: column beat -> window -> 4-stage coefficient units -> registered m_tdata, m_tvalid.
// Throughput: 1 column per cycle without a result; a column with results blocks input until
//   they are loaded, m_tready permitting; a row-end column takes 3 stencil passes.
// Reset: rst_n async active low clears window, column count, config and control state.
module srad_diffusion_coeff_stencil_core
    import srad_pkg::*;
#(
    parameter int ROW_WIDTH = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    // pixel_above, pixel_center, pixel_below, pixel_below_two
    input  logic [4*PIX_W-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // ctr_val, ctr_den, sth_val, sth_den, est_val, est_den
    output logic [6*COEF_W-1:0] m_tdata,
    output logic                m_tlast
);
    logic [15:0] q0_reg;
    logic        byp_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q0_reg  <= '0;
            byp_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_Q0)     q0_reg  <= cfg_data[15:0];
            if (cfg_index == REG_BYPASS) byp_reg <= cfg_data[0];
        end
    end

    srad_cmd_t cmd;
    srad_sts_t sts;
    logic out_load;
    logic [6*COEF_W-1:0] res;

    srad_ctrl #(.ROW_WIDTH(ROW_WIDTH)) u_ctrl (.clk, .rst_n, .in_valid(s_tvalid),
        .in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
        .out_last(m_tlast), .out_load, .cmd, .sts);

    srad_datapath u_dp (.clk, .rst_n, .cmd, .sts, .q0(q0_reg), .bypass(byp_reg),
        .col_in(s_tdata), .res);

    always_ff @(posedge clk)
    begin
        if (out_load) m_tdata <= res;
    end
endmodule

FILE: bench/tb_srad_diffusion_coeff_stencil_core.sv
`timescale 1ns / 1ps

module tb_srad_diffusion_coeff_stencil_core
    import srad_pkg::*;
();

    localparam int ROW_W     = 256;
    localparam int RND_ITEMS = 174;

    // index past the two registers, must be ignored
    localparam logic [IDX_W-1:0] REG_SPARE = 8'd7;

    typedef struct packed {
        logic [COEF_W-1:0] e_tag;
        logic [COEF_W-1:0] e_val;
        logic [COEF_W-1:0] s_tag;
        logic [COEF_W-1:0] s_val;
        logic [COEF_W-1:0] c_tag;
        logic [COEF_W-1:0] c_val;
        logic              last;
    } coef_beat_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]    cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [4*PIX_W-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [6*COEF_W-1:0] m_tdata;
    logic                m_tlast;

    // model state
    logic [15:0]  q0_sq;
    logic         bypass_on;
    logic [15:0]  win [0:2][0:3];
    int           col_cnt;

    coef_beat_t   coef_queue[$];
    int           n_err;
    int           n_rcv;
    int           hold_cycles;
    bit           long_gaps;

    srad_diffusion_coeff_stencil_core #(.ROW_WIDTH(ROW_W)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #10 clk = ~clk;

    // shift a 128-bit product right by 28, saturate to 48 bits
    function automatic logic [47:0] scale_q24(input logic [127:0] x);
        logic [127:0] y;
        y = x >> 28;
        if (y[127:48] != 0)
            return SAT48;
        return y[47:0];
    endfunction

    // one diffusion coefficient from a four-neighbor stencil
    function automatic void diff_coef(input logic [15:0] pn, input logic [15:0] pc,
                                      input logic [15:0] ps, input logic [15:0] pw,
                                      input logic [15:0] pe,
                                      output logic [47:0] v, output logic [47:0] t);
        logic [127:0] a, c4, b, sq, nq, numw, denw, q;
        logic [47:0]  num, den;
        q = q0_sq;
        if (bypass_on || q0_sq == 0 || pc == 0)
        begin
            v = ONE_Q24;
            t = '0;
            return;
        end
        a  = 128'(pn) + ps + pw + pe;
        c4 = 128'(pc) * 4;
        b  = (a >= c4) ? a - c4 : c4 - a;
        sq = 128'(pn > pc ? pn - pc : pc - pn) ** 2
           + 128'(ps > pc ? ps - pc : pc - ps) ** 2
           + 128'(pw > pc ? pw - pc : pc - pw) ** 2
           + 128'(pe > pc ? pe - pc : pc - pe) ** 2;
        nq   = 8 * sq - b * b;
        numw = q * (65536 + q) * a * a;
        denw = (nq << 32) + q * q * a * a;
        num  = scale_q24(numw);
        den  = scale_q24(denw);
        if (num == 0 || den == 0)
        begin
            v = '0;
            t = '0;
        end
        else if (den <= num)
        begin
            v = ONE_Q24;
            t = '0;
        end
        else
        begin
            v = num;
            t = den;
        end
    endfunction

    // result for the column whose left neighbor sits at cols[k]
    function automatic coef_beat_t column_coefs(input logic [15:0] cols [0:5][0:3],
                                                input int k, input logic last);
        coef_beat_t r;
        diff_coef(cols[k+1][0], cols[k+1][1], cols[k+1][2], cols[k][1], cols[k+2][1],
                  r.c_val, r.c_tag);
        diff_coef(cols[k+1][1], cols[k+1][2], cols[k+1][3], cols[k][2], cols[k+2][2],
                  r.s_val, r.s_tag);
        diff_coef(cols[k+2][0], cols[k+2][1], cols[k+2][2], cols[k+1][1], cols[k+3][1],
                  r.e_val, r.e_tag);
        r.last = last;
        return r;
    endfunction

    // advance the window model by one column and queue expected results
    function automatic void predict_column(input logic [4*PIX_W-1:0] d);
        logic [15:0] cols [0:5][0:3];
        for (int i = 0; i < 6; i++)
            for (int r = 0; r < 4; r++)
                cols[i][r] = '0;
        for (int i = 0; i < 3; i++)
            for (int r = 0; r < 4; r++)
                cols[i][r] = (col_cnt == 0) ? 16'h0 : win[i][r];
        for (int r = 0; r < 4; r++)
            cols[3][r] = d[r*PIX_W +: PIX_W];
        if (col_cnt >= ROW_W - 1)
        begin
            coef_queue.push_back(column_coefs(cols, 0, 1'b0));
            coef_queue.push_back(column_coefs(cols, 1, 1'b0));
            coef_queue.push_back(column_coefs(cols, 2, 1'b1));
            col_cnt = 0;
        end
        else
        begin
            if (col_cnt >= 2)
                coef_queue.push_back(column_coefs(cols, 0, 1'b0));
            col_cnt++;
        end
        for (int i = 0; i < 3; i++)
            for (int r = 0; r < 4; r++)
                win[i][r] = cols[i+1][r];
    endfunction

    function automatic int rand_gap();
        if (long_gaps && $urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    // valid stays high into the next beat when there is no gap
    task automatic send_column(input logic [4*PIX_W-1:0] d);
        int g;
        g = rand_gap();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        predict_column(d);
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_Q0)
            q0_sq = val[15:0];
        else if (idx == REG_BYPASS)
            bypass_on = val[0];
        @(posedge clk);
    endtask

    // stop sending, wait for all outstanding results, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (coef_queue.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_pix();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(16'h0100 + $urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [4*PIX_W-1:0] rand_column();
        return {rand_pix(), rand_pix(), rand_pix(), rand_pix()};
    endfunction

    task automatic send_row(input int n);
        for (int k = 0; k < n; k++)
            send_column(rand_column());
    endtask

    // extremes of the pixel fields and a zero center at the start of a row
    task automatic test_directed();
        write_reg(REG_Q0, 32'h0000_4000);
        send_column({4{16'hFFFF}});
        send_column({16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_column({16'h0100, 16'h0000, 16'h0200, 16'h0080});
        send_column({16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001});
        send_column(64'h5555_AAAA_5555_AAAA);
        send_column(64'hAAAA_5555_AAAA_5555);
        send_column({4{16'h0100}});
        send_row(20);
        drain();
        // wider q0 extremes and bypass
        write_reg(REG_Q0, 32'h0000_FFFF);
        send_row(20);
        drain();
        write_reg(REG_BYPASS, 32'h1);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_row(10);
        drain();
        write_reg(REG_BYPASS, 32'h0);
        write_reg(REG_Q0, 32'h0);
        send_row(10);
        drain();
    endtask

    // random data with random settings, idles on both sides
    task automatic test_random();
        int sent;
        sent = 0;
        long_gaps = 1'b1;
        write_reg(REG_Q0, 32'h0000_0001);
        while (sent < RND_ITEMS)
        begin
            send_column(rand_column());
            sent++;
            if ($urandom_range(0, 39) == 0)
            begin
                drain();
                write_reg(REG_Q0, {16'h0, 16'($urandom)});
                write_reg(REG_BYPASS, 32'($urandom_range(0, 1)));
            end
        end
        drain();
    endtask

    // receiver holds off while columns keep coming, row end included
    task automatic test_backpressure();
        long_gaps = 1'b0;
        write_reg(REG_BYPASS, 32'h0);
        write_reg(REG_Q0, 32'h0000_0800);
        hold_cycles = 300;
        send_row(ROW_W - col_cnt);
        drain();
    endtask

    // receiver side: random stalls plus the long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else if (long_gaps && $urandom_range(0, 29) == 0)
            begin
                m_tready <= 1'b0;
                hold_cycles = $urandom_range(10, 40);
            end
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        coef_beat_t got;
        coef_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata, m_tlast};
            n_rcv++;
            if (coef_queue.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result beat %0d: %h", n_rcv, got);
            end
            else
            begin
                want = coef_queue.pop_front();
                if (got !== want)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("beat %0d mismatch: exp %h act %h", n_rcv, want, got);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        q0_sq     = '0;
        bypass_on = 1'b0;
        col_cnt   = 0;
        n_err     = 0;
        n_rcv     = 0;
        hold_cycles = 0;
        long_gaps = 1'b0;
        for (int i = 0; i < 3; i++)
            for (int r = 0; r < 4; r++)
                win[i][r] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random();

        if (n_err == 0 && coef_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/srad_pkg.sv
hw/rtl/srad_coeff.sv
hw/rtl/srad_datapath.sv
hw/rtl/srad_ctrl.sv
hw/rtl/srad_diffusion_coeff_stencil_core.sv
bench/tb_srad_diffusion_coeff_stencil_core.sv
